### hw/rtl/lbg_pkg.sv
`default_nettype none
package lbg_pkg;

	// Input transaction payload.
	typedef struct packed {
		logic [1:0]         action;
		logic signed [31:0] coef_zero;
		logic signed [31:0] coef_one;
		logic signed [31:0] coef_two;
		logic signed [31:0] coef_three;
		logic [7:0]         confidence;
		logic [22:0]        speed;
	} in_t;

	// Result transaction payload.
	typedef struct packed {
		logic               valid_res;
		logic signed [31:0] distance;
		logic signed [23:0] heading_deg;
		logic signed [23:0] lateral_rate;
		logic signed [31:0] curvature;
		logic signed [31:0] curvature_rate;
		logic [19:0]        crossing_time;
		logic               lane_change;
	} out_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_WHEEL_BASE = 2'd0;
	localparam logic [1:0] CFG_HOST_WIDTH = 2'd1;

	localparam logic [19:0] WHEEL_BASE_RST = 20'd183501;
	localparam logic [18:0] HOST_WIDTH_RST = 19'd124518;

	localparam int HOLD_FRAMES = 15;
	localparam int HOLD_W      = 5;

	// Fixed-point constants.
	localparam logic signed [31:0] Q16_ONE      = 32'sd65536;
	localparam logic [19:0]        TTC_MAX      = 20'd655360;
	localparam logic [22:0]        RATE_MIN     = 23'd66;
	localparam logic signed [32:0] JUMP_THR     = 33'sd163840;
	localparam logic signed [31:0] NEAR_THR     = 32'sd6554;
	localparam logic signed [31:0] OFFSET_RESET = 32'sd117965;
	localparam int                 HDG_LIM      = 5898240;
	localparam int                 LAT_LIM      = 6553600;

	// Shared multiplier geometry.
	localparam int MUL_A_W = 35;
	localparam int MUL_B_W = 30;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;

	// Working width of the polynomial accumulators.
	localparam int ACC_W = 48;

	// CORDIC geometry.
	localparam int CORDIC_STEPS = 23;
	localparam int CIDX_W       = 5;
	localparam int XY_W         = 36;
	localparam int UV_W         = 34;
	localparam int Z_W          = 26;
	localparam logic signed [UV_W-1:0] KINV_Q30 = 34'sd652032874;

	// Divider geometry: quotient bits after the overflow test.
	localparam int DIV_STEPS = 20;
	localparam int DIV_CNT_W = 5;

	// Saturate a wide signed value to 32 bits.
	function automatic logic signed [31:0] sat_s32(input logic signed [ACC_W-1:0] x);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = 48'sd2147483647;
		lo = -48'sd2147483648;
		if (x > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (x < lo) begin
			return 32'sh8000_0000;
		end
		return x[31:0];
	endfunction

	// atan(2^-i) in degrees, Q16.16.
	function automatic logic [21:0] atan_deg(input logic [CIDX_W-1:0] i);
		case (i)
			5'd0:  return 22'd2949120;
			5'd1:  return 22'd1740967;
			5'd2:  return 22'd919879;
			5'd3:  return 22'd466945;
			5'd4:  return 22'd234379;
			5'd5:  return 22'd117304;
			5'd6:  return 22'd58666;
			5'd7:  return 22'd29335;
			5'd8:  return 22'd14668;
			5'd9:  return 22'd7334;
			5'd10: return 22'd3667;
			5'd11: return 22'd1833;
			5'd12: return 22'd917;
			5'd13: return 22'd458;
			5'd14: return 22'd229;
			5'd15: return 22'd115;
			5'd16: return 22'd57;
			5'd17: return 22'd29;
			5'd18: return 22'd14;
			5'd19: return 22'd7;
			5'd20: return 22'd4;
			5'd21: return 22'd2;
			5'd22: return 22'd1;
			default: return 22'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

### hw/rtl/lbg_mul.sv
`default_nettype none
// Shared signed-by-unsigned multiplier with a registered product.
module lbg_mul (
	input  wire logic                                   clk,
	input  wire logic signed [lbg_pkg::MUL_A_W-1:0]     a,
	input  wire logic [lbg_pkg::MUL_B_W-1:0]            b,
	output logic signed [lbg_pkg::PROD_W-1:0]           prod_q
);

	logic signed [lbg_pkg::PROD_W:0] prod_full;

	// The unsigned operand gets a zero sign bit.
	assign prod_full = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		prod_q <= prod_full[lbg_pkg::PROD_W-1:0];
	end

endmodule
`default_nettype wire

### hw/rtl/lbg_cordic.sv
`default_nettype none
// Iterative CORDIC: one vectoring step per cycle, with a second vector
// rotated by the same decisions to give the sine.
module lbg_cordic (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic signed [31:0]                 slope,
	output logic                                    done,
	output logic signed [lbg_pkg::Z_W-1:0]          deg,
	output logic signed [lbg_pkg::UV_W-1:0]         sine
);

	logic                                 run_q;
	logic [lbg_pkg::CIDX_W-1:0]           idx_q;
	logic signed [lbg_pkg::XY_W-1:0]      x_q, y_q, xs, ys;
	logic signed [lbg_pkg::UV_W-1:0]      u_q, v_q, us, vs;
	logic signed [lbg_pkg::Z_W-1:0]       z_q, ang;

	// Shifted operands for the current step.
	assign xs  = x_q >>> idx_q;
	assign ys  = y_q >>> idx_q;
	assign us  = u_q >>> idx_q;
	assign vs  = v_q >>> idx_q;
	assign ang = $signed({4'b0, lbg_pkg::atan_deg(idx_q)});

	assign deg  = z_q;
	assign sine = v_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			idx_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				idx_q <= '0;
			end else if (run_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == lbg_pkg::CIDX_W'(lbg_pkg::CORDIC_STEPS - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= lbg_pkg::XY_W'(36'sd16777216);
			y_q <= -(lbg_pkg::XY_W'(slope));
			z_q <= '0;
			u_q <= lbg_pkg::KINV_Q30;
			v_q <= '0;
		end else if (run_q) begin
			if (!y_q[lbg_pkg::XY_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + ang;
				u_q <= u_q - vs;
				v_q <= v_q + us;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - ang;
				u_q <= u_q + vs;
				v_q <= v_q - us;
			end
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lbg_div.sv
`default_nettype none
// Restoring divider for the crossing time: (num << 16) / den, clamped.
// An overflowing quotient is detected up front, so only the low quotient
// bits are iterated, one per cycle.
module lbg_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [30:0]  num,
	input  wire logic [22:0]  den,
	output logic              done,
	output logic [19:0]       quot
);

	logic                              run_q;
	logic [lbg_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [22:0]                       rem_q;
	logic [19:0]                       bits_q;
	logic [19:0]                       q_q;
	logic [22:0]                       den_q;
	logic [23:0]                       trial;
	logic                              fit;

	assign trial = {rem_q, bits_q[19]};
	assign fit   = trial >= {1'b0, den_q};
	assign quot  = (q_q > lbg_pkg::TTC_MAX) ? lbg_pkg::TTC_MAX : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				// Quotient of 2^20 or more clamps at once.
				if (num[30:4] >= {4'b0, den}) begin
					done <= 1'b1;
				end else begin
					run_q <= 1'b1;
				end
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == lbg_pkg::DIV_CNT_W'(lbg_pkg::DIV_STEPS - 1)) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q  <= den;
			rem_q  <= num[26:4];
			bits_q <= {num[3:0], 16'b0};
			q_q    <= (num[30:4] >= {4'b0, den}) ? lbg_pkg::TTC_MAX : '0;
		end else if (run_q) begin
			bits_q <= {bits_q[18:0], 1'b0};
			q_q    <= {q_q[18:0], fit};
			rem_q  <= fit ? 23'(trial - {1'b0, den_q}) : trial[22:0];
		end
	end

endmodule
`default_nettype wire

### hw/rtl/lane_boundary_geometry_core.sv
`default_nettype none
// Channel | Direction | Signals
// in      | input     | in_valid, in_ready, in_data (lbg_pkg::in_t)
// out     | output    | out_valid, out_ready, out_data (lbg_pkg::out_t)
// cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data
//
// A valid boundary runs through 8 shared multiplies, the CORDIC start and its
// 23 steps, the lateral-rate multiply, the divider start and its 20 steps, and
// the load of the output register. A distance of zero or below skips the
// divider, and a quotient that clamps at once ends it early. An invalid
// boundary goes straight to the output register. in_ready is high only while
// idle, from the cycle after the result is loaded, so a new boundary is taken
// only once the last one is through. A finished result waits until the output
// register is free. Reset is asynchronous.
module lane_boundary_geometry_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire lbg_pkg::in_t    in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output lbg_pkg::out_t        out_data,
	input  wire logic            cfg_valid,
	output logic                 cfg_ready,
	input  wire logic [1:0]      cfg_index,
	input  wire logic [19:0]     cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_MUL_ISSUE, S_MUL_ACC, S_CORDIC_START, S_CORDIC_WAIT,
		S_LAT_ISSUE, S_LAT_ACC, S_DIV_START, S_DIV_WAIT, S_DONE
	} state_t;

	state_t                              state_q;
	lbg_pkg::in_t                        item_q;
	logic                                vld_q, right_q, lc_q;
	logic [2:0]                          op_q;
	logic [19:0]                         wb_q;
	logic [18:0]                         hw_q;
	logic [23:0]                         wb2_q;
	logic [27:0]                         wb3_q;
	logic signed [lbg_pkg::ACC_W-1:0]    a0_q, a1_q, a2_q;
	logic signed [31:0]                  dist_q, curv_q;
	logic signed [23:0]                  hdg_q, lat_q;
	logic signed [lbg_pkg::UV_W-1:0]     sine_q;
	logic [19:0]                         ttc_q;

	// Lane-change tracking state.
	logic signed [31:0]                  prev_l_q, prev_r_q;
	logic                                pvld_l_q, pvld_r_q, flag_l_q, flag_r_q;
	logic [lbg_pkg::HOLD_W-1:0]          cnt_l_q, cnt_r_q;

	// Shared multiplier.
	logic signed [lbg_pkg::MUL_A_W-1:0]  mul_a;
	logic [lbg_pkg::MUL_B_W-1:0]         mul_b;
	logic signed [lbg_pkg::PROD_W-1:0]   prod_q, sh16, sh24, sh30;

	logic signed [lbg_pkg::MUL_A_W-1:0]  c1_x, c2_x, c3_x;

	// CORDIC and divider hookup.
	logic                                cor_start, cor_done;
	logic signed [31:0]                  a1_sat;
	logic signed [lbg_pkg::Z_W-1:0]      cor_deg;
	logic signed [lbg_pkg::UV_W-1:0]     cor_sine;
	logic                                div_start, div_done;
	logic [22:0]                         div_den;
	logic [19:0]                         div_quot;
	logic signed [24:0]                  rate;

	// Distance and curvature from the accumulators.
	logic signed [31:0]                  a0_sat;
	logic signed [lbg_pkg::ACC_W-1:0]    dist_w, curv_w;

	// Lane-change decision for the incoming item.
	logic                                in_vld, in_right, in_marker, jump;
	logic signed [31:0]                  prev_sel;
	logic                                pvld_sel, flag_sel, flag_new;
	logic [lbg_pkg::HOLD_W-1:0]          cnt_sel, cnt_new;
	logic [lbg_pkg::HOLD_W:0]            cnt_inc;
	logic signed [32:0]                  diff;
	logic                                in_take;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && in_ready;

	assign c1_x = lbg_pkg::MUL_A_W'(item_q.coef_one);
	assign c2_x = lbg_pkg::MUL_A_W'(item_q.coef_two);
	assign c3_x = lbg_pkg::MUL_A_W'(item_q.coef_three);

	// Operand select for the multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == S_LAT_ISSUE) begin
			mul_a = lbg_pkg::MUL_A_W'(sine_q);
			mul_b = lbg_pkg::MUL_B_W'(item_q.speed);
		end else begin
			case (op_q)
				3'd0: begin
					mul_a = $signed({15'b0, wb_q});
					mul_b = lbg_pkg::MUL_B_W'(wb_q);
				end
				3'd1: begin
					mul_a = $signed({11'b0, wb2_q});
					mul_b = lbg_pkg::MUL_B_W'(wb_q);
				end
				3'd2: begin
					mul_a = c1_x;
					mul_b = lbg_pkg::MUL_B_W'(wb_q);
				end
				3'd3: begin
					mul_a = c2_x;
					mul_b = lbg_pkg::MUL_B_W'(wb2_q);
				end
				3'd4: begin
					mul_a = c3_x;
					mul_b = lbg_pkg::MUL_B_W'(wb3_q);
				end
				3'd5: begin
					mul_a = c2_x <<< 1;
					mul_b = lbg_pkg::MUL_B_W'(wb_q);
				end
				3'd6: begin
					mul_a = c3_x + (c3_x <<< 1);
					mul_b = lbg_pkg::MUL_B_W'(wb2_q);
				end
				default: begin
					mul_a = c3_x + (c3_x <<< 1);
					mul_b = lbg_pkg::MUL_B_W'(wb_q);
				end
			endcase
		end
	end

	lbg_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	assign sh16 = prod_q >>> 16;
	assign sh24 = prod_q >>> 24;
	assign sh30 = prod_q >>> 30;

	// Shifted polynomial terms and saturation.
	assign a0_sat = lbg_pkg::sat_s32(a0_q);
	assign a1_sat = lbg_pkg::sat_s32(a1_q);
	assign dist_w = (right_q ? -lbg_pkg::ACC_W'(a0_sat) : lbg_pkg::ACC_W'(a0_sat))
		- $signed({30'b0, hw_q[18:1]});
	assign curv_w = a2_q <<< 1;

	assign cor_start = (state_q == S_CORDIC_START);

	lbg_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.slope  (a1_sat),
		.done   (cor_done),
		.deg    (cor_deg),
		.sine   (cor_sine)
	);

	// Approach rate, held at or above the minimum.
	assign rate      = right_q ? -25'(lat_q) : 25'(lat_q);
	assign div_den   = (rate < $signed({2'b0, lbg_pkg::RATE_MIN})) ?
		lbg_pkg::RATE_MIN : rate[22:0];
	assign div_start = (state_q == S_DIV_START) && (dist_q > 32'sd0);

	lbg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (dist_q[30:0]),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Lane-change jump detection on the side of the incoming item.
	always_comb begin
		in_vld    = (in_data.confidence != 8'd0);
		in_right  = in_data.action[0];
		in_marker = !in_data.action[1];
		prev_sel  = in_right ? prev_r_q : prev_l_q;
		pvld_sel  = in_right ? pvld_r_q : pvld_l_q;
		flag_sel  = in_right ? flag_r_q : flag_l_q;
		cnt_sel   = in_right ? cnt_r_q : cnt_l_q;
		diff      = 33'(in_data.coef_zero) - 33'(prev_sel);
		jump      = in_vld && pvld_sel && (prev_sel < lbg_pkg::NEAR_THR)
			&& (prev_sel > -lbg_pkg::NEAR_THR)
			&& (in_right ? (diff < -lbg_pkg::JUMP_THR) : (diff > lbg_pkg::JUMP_THR));
		cnt_inc   = {1'b0, cnt_sel} + 1'b1;
		if (jump) begin
			cnt_new  = '0;
			flag_new = 1'b1;
		end else if (cnt_inc > (lbg_pkg::HOLD_W + 1)'(lbg_pkg::HOLD_FRAMES)) begin
			cnt_new  = '0;
			flag_new = 1'b0;
		end else begin
			cnt_new  = cnt_inc[lbg_pkg::HOLD_W-1:0];
			flag_new = flag_sel;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= lbg_pkg::WHEEL_BASE_RST;
			hw_q <= lbg_pkg::HOST_WIDTH_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == lbg_pkg::CFG_WHEEL_BASE) begin
				wb_q <= cfg_data;
			end else if (cfg_index == lbg_pkg::CFG_HOST_WIDTH) begin
				hw_q <= cfg_data[18:0];
			end
		end
	end

	// Lane-change history, updated when a marker transaction is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_l_q <= lbg_pkg::OFFSET_RESET;
			prev_r_q <= -lbg_pkg::OFFSET_RESET;
			pvld_l_q <= 1'b0;
			pvld_r_q <= 1'b0;
			flag_l_q <= 1'b0;
			flag_r_q <= 1'b0;
			cnt_l_q  <= '0;
			cnt_r_q  <= '0;
		end else if (in_take && in_marker) begin
			if (in_right) begin
				prev_r_q <= in_data.coef_zero;
				pvld_r_q <= in_vld;
				flag_r_q <= flag_new;
				cnt_r_q  <= cnt_new;
			end else begin
				prev_l_q <= in_data.coef_zero;
				pvld_l_q <= in_vld;
				flag_l_q <= flag_new;
				cnt_l_q  <= cnt_new;
			end
		end
	end

	// Sequencer with its registered results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			op_q      <= '0;
			out_valid <= 1'b0;
		end else begin
			// The done state reloads the output register itself.
			if (out_valid && out_ready && (state_q != S_DONE)) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						item_q  <= in_data;
						vld_q   <= in_vld;
						right_q <= in_right;
						lc_q    <= in_marker && flag_new;
						op_q    <= '0;
						a0_q    <= lbg_pkg::ACC_W'(in_data.coef_zero);
						a1_q    <= lbg_pkg::ACC_W'(in_data.coef_one);
						a2_q    <= lbg_pkg::ACC_W'(in_data.coef_two);
						state_q <= in_vld ? S_MUL_ISSUE : S_DONE;
					end
				end
				S_MUL_ISSUE: begin
					state_q <= S_MUL_ACC;
				end
				S_MUL_ACC: begin
					case (op_q)
						3'd0: wb2_q <= prod_q[39:16];
						3'd1: wb3_q <= prod_q[43:16];
						3'd2, 3'd3, 3'd4: a0_q <= a0_q + sh24[lbg_pkg::ACC_W-1:0];
						3'd5, 3'd6: a1_q <= a1_q + sh16[lbg_pkg::ACC_W-1:0];
						default: a2_q <= a2_q + sh16[lbg_pkg::ACC_W-1:0];
					endcase
					op_q    <= op_q + 1'b1;
					state_q <= (op_q == 3'd7) ? S_CORDIC_START : S_MUL_ISSUE;
				end
				S_CORDIC_START: begin
					dist_q  <= lbg_pkg::sat_s32(dist_w);
					curv_q  <= lbg_pkg::sat_s32(curv_w);
					state_q <= S_CORDIC_WAIT;
				end
				S_CORDIC_WAIT: begin
					if (cor_done) begin
						if (cor_deg > lbg_pkg::Z_W'(lbg_pkg::HDG_LIM)) begin
							hdg_q <= 24'(lbg_pkg::HDG_LIM);
						end else if (cor_deg < -lbg_pkg::Z_W'(lbg_pkg::HDG_LIM)) begin
							hdg_q <= -24'(lbg_pkg::HDG_LIM);
						end else begin
							hdg_q <= cor_deg[23:0];
						end
						sine_q  <= cor_sine;
						state_q <= S_LAT_ISSUE;
					end
				end
				S_LAT_ISSUE: begin
					state_q <= S_LAT_ACC;
				end
				S_LAT_ACC: begin
					if (sh30 > lbg_pkg::PROD_W'(lbg_pkg::LAT_LIM)) begin
						lat_q <= 24'(lbg_pkg::LAT_LIM);
					end else if (sh30 < -lbg_pkg::PROD_W'(lbg_pkg::LAT_LIM)) begin
						lat_q <= -24'(lbg_pkg::LAT_LIM);
					end else begin
						lat_q <= sh30[23:0];
					end
					state_q <= S_DIV_START;
				end
				S_DIV_START: begin
					if (dist_q > 32'sd0) begin
						state_q <= S_DIV_WAIT;
					end else begin
						ttc_q   <= '0;
						state_q <= S_DONE;
					end
				end
				S_DIV_WAIT: begin
					if (div_done) begin
						ttc_q   <= div_quot;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid              <= 1'b1;
						out_data.valid_res     <= vld_q;
						out_data.lane_change   <= lc_q;
						if (vld_q) begin
							out_data.distance       <= dist_q;
							out_data.heading_deg    <= hdg_q;
							out_data.lateral_rate   <= lat_q;
							out_data.curvature      <= curv_q;
							out_data.curvature_rate <= item_q.coef_three;
							out_data.crossing_time  <= ttc_q;
						end else begin
							out_data.distance       <= lbg_pkg::Q16_ONE;
							out_data.heading_deg    <= '0;
							out_data.lateral_rate   <= '0;
							out_data.curvature      <= '0;
							out_data.curvature_rate <= '0;
							out_data.crossing_time  <= lbg_pkg::TTC_MAX;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### bench/tb.sv
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Lane-change detection parameters and geometry limits.
	localparam int                HOLD_LEN    = 15;
	localparam logic signed [63:0] JUMP_M      = 64'sd163840;
	localparam logic signed [63:0] NEAR_M      = 64'sd6554;
	localparam logic signed [63:0] HDG_MAX     = 64'sd5898240;
	localparam logic signed [63:0] LAT_MAX     = 64'sd6553600;
	localparam logic signed [63:0] TTC_CAP     = 64'sd655360;
	localparam logic signed [63:0] RATE_FLOOR  = 64'sd66;
	localparam logic signed [63:0] GAIN_Q30    = 64'sd652032874;
	localparam logic signed [63:0] S32_MAX     = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN     = -64'sd2147483648;
	localparam int                 ROT_STEPS   = 23;
	localparam int                 CYCLE_LIMIT = 900000;
	localparam int                 DRAIN_WAIT  = 100;

	// Boundary kinds.
	typedef enum logic [1:0] {
		LEFT_MARKER  = 2'd0,
		RIGHT_MARKER = 2'd1,
		LEFT_EDGE    = 2'd2,
		RIGHT_EDGE   = 2'd3
	} boundary_kind_e;

	// Rotation angles atan(2^-i) in degrees, Q16.16.
	localparam logic signed [63:0] ROT_ANGLE [ROT_STEPS] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	lbg_pkg::in_t  in_data;
	logic out_valid;
	logic out_ready;
	lbg_pkg::out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0]  cfg_index;
	logic [19:0] cfg_data;

	lane_boundary_geometry_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the vehicle registers and the side tracking state.
	logic [19:0] wheel_base_q;
	logic [18:0] host_width_q;
	logic signed [31:0] last_offset [2];
	logic last_valid [2];
	logic change_flag [2];
	int   hold_count [2];

	lbg_pkg::out_t expected_geometry [$];
	int   error_count;
	int   burst_left;
	int   cycle_count;
	logic long_hold_req;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// Work out the geometry of one boundary and advance the side tracking.
	function automatic lbg_pkg::out_t predict_boundary(input lbg_pkg::in_t item);
		lbg_pkg::out_t r;
		logic signed [63:0] c0, c1, c2, c3, spd, wb, wb2, wb3;
		logic signed [63:0] a0, a1, a2, side_dist, rate, lat, diff;
		logic signed [63:0] x, y, z, u, v, xs, ys, us, vs;
		logic ok, is_right, jump;
		int side;
		c0 = item.coef_zero;
		c1 = item.coef_one;
		c2 = item.coef_two;
		c3 = item.coef_three;
		spd = {41'd0, item.speed};
		ok = item.confidence != 8'd0;
		is_right = item.action[0];
		r = '0;
		r.distance = 32'sd65536;
		r.crossing_time = 20'd655360;
		r.valid_res = ok;
		if (ok) begin
			wb = {44'd0, wheel_base_q};
			wb2 = (wb * wb) >>> 16;
			wb3 = (wb2 * wb) >>> 16;
			a0 = c0 + ((c1 * wb) >>> 24) + ((c2 * wb2) >>> 24) + ((c3 * wb3) >>> 24);
			a0 = clamp(a0, S32_MIN, S32_MAX);
			a1 = c1 + ((2 * c2 * wb) >>> 16) + ((3 * c3 * wb2) >>> 16);
			a1 = clamp(a1, S32_MIN, S32_MAX);
			a2 = c2 + ((3 * c3 * wb) >>> 16);
			r.curvature = clamp(2 * a2, S32_MIN, S32_MAX);
			r.curvature_rate = item.coef_three;
			side_dist = (is_right ? -a0 : a0) - $signed({46'd0, host_width_q[18:1]});
			side_dist = clamp(side_dist, S32_MIN, S32_MAX);
			r.distance = side_dist[31:0];
			// Vectoring on the slope, rotating the gain vector alongside.
			x = 64'sd1 <<< 24;
			y = -a1;
			z = 0;
			u = GAIN_Q30;
			v = 0;
			for (int i = 0; i < ROT_STEPS; i++) begin
				xs = x >>> i;
				ys = y >>> i;
				us = u >>> i;
				vs = v >>> i;
				if (y >= 0) begin
					x = x + ys; y = y - xs; z = z + ROT_ANGLE[i];
					u = u - vs; v = v + us;
				end else begin
					x = x - ys; y = y + xs; z = z - ROT_ANGLE[i];
					u = u + vs; v = v - us;
				end
			end
			z = clamp(z, -HDG_MAX, HDG_MAX);
			r.heading_deg = z[23:0];
			lat = clamp((spd * v) >>> 30, -LAT_MAX, LAT_MAX);
			r.lateral_rate = lat[23:0];
			rate = is_right ? -lat : lat;
			if (rate < RATE_FLOOR) begin
				rate = RATE_FLOOR;
			end
			if (side_dist <= 0) begin
				r.crossing_time = '0;
			end else begin
				side_dist = clamp((side_dist * 65536) / rate, 0, TTC_CAP);
				r.crossing_time = side_dist[19:0];
			end
		end
		// Lane-change tracking for marker kinds only.
		if (!item.action[1]) begin
			side = is_right ? 1 : 0;
			diff = c0 - 64'(last_offset[side]);
			jump = ok && last_valid[side] && last_offset[side] < NEAR_M &&
				last_offset[side] > -NEAR_M && (is_right ? diff < -JUMP_M : diff > JUMP_M);
			if (jump) begin
				hold_count[side] = 0;
				change_flag[side] = 1'b1;
			end else if (hold_count[side] + 1 > HOLD_LEN) begin
				hold_count[side] = 0;
				change_flag[side] = 1'b0;
			end else begin
				hold_count[side]++;
			end
			last_offset[side] = item.coef_zero;
			last_valid[side] = ok;
			r.lane_change = change_flag[side];
		end
		return r;
	endfunction

	// Offer one boundary, in bursts separated by random gaps.
	task automatic send_boundary(input lbg_pkg::in_t item);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 10);
		end
		burst_left--;
		in_valid = 1'b1;
		in_data = item;
		do @(posedge clk); while (!in_ready);
		expected_geometry.push_back(predict_boundary(item));
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	task automatic send_fields(input boundary_kind_e kind, input logic [31:0] c0,
			input logic [31:0] c1, input logic [31:0] c2, input logic [31:0] c3,
			input logic [7:0] conf, input logic [22:0] spd);
		lbg_pkg::in_t item;
		item.action = kind;
		item.coef_zero = c0;
		item.coef_one = c1;
		item.coef_two = c2;
		item.coef_three = c3;
		item.confidence = conf;
		item.speed = spd;
		send_boundary(item);
	endtask

	// Let every result drain, then let the block go fully idle.
	task automatic wait_idle();
		while (expected_geometry.size() != 0) @(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// Write one vehicle register while the block is idle.
	task automatic write_register(input logic [1:0] idx, input logic [19:0] value);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		if (idx == lbg_pkg::CFG_WHEEL_BASE) begin
			wheel_base_q = value;
		end else if (idx == lbg_pkg::CFG_HOST_WIDTH) begin
			host_width_q = value[18:0];
		end
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// A realistic boundary with random content.
	task automatic send_road_like(input boundary_kind_e kind, input logic signed [31:0] c0);
		send_fields(kind, c0, $urandom_range(0, 1 << 24) - (1 << 23),
			$urandom_range(0, 1 << 19) - (1 << 18), $urandom_range(0, 1 << 15) - (1 << 14),
			($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)),
			$urandom_range(0, 6553600));
	endtask

	// Field extremes, every kind, and invalid boundaries.
	task automatic test_extremes();
		send_fields(LEFT_EDGE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			8'hFF, 23'h7FFFFF);
		send_fields(RIGHT_EDGE, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
			8'd1, 23'd6553600);
		send_fields(LEFT_EDGE, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h80000000,
			8'd1, 23'd0);
		send_fields(RIGHT_EDGE, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h0,
			8'd200, 23'h7FFFFF);
		send_fields(LEFT_MARKER, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			8'd0, 23'h7FFFFF);
		send_fields(RIGHT_MARKER, 32'd0, 32'd0, 32'd0, 32'd0, 8'd128, 23'd0);
		// Zero distance gives zero time; tiny rate saturates to the ceiling.
		send_fields(LEFT_EDGE, 32'd62259, 32'd0, 32'd0, 32'd0, 8'd5, 23'd1000000);
		send_fields(LEFT_EDGE, 32'd300000, 32'd0, 32'd0, 32'd0, 8'd5, 23'd0);
		// Steep slopes drive the heading and lateral rate toward their limits.
		send_fields(RIGHT_EDGE, -32'sd100000, 32'h40000000, 32'd0, 32'd0, 8'd9, 23'd6553600);
		send_fields(LEFT_EDGE, 32'sd400000, 32'hC0000000, 32'd0, 32'd0, 8'd9, 23'd6553600);
	endtask

	// Jumps on both sides and the expiry of the held flag.
	task automatic test_lane_change();
		send_fields(LEFT_MARKER, 32'd0, 32'd0, 32'd0, 32'd0, 8'd50, 23'd1000000);
		send_fields(LEFT_MARKER, 32'd200000, 32'd0, 32'd0, 32'd0, 8'd50, 23'd1000000);
		send_fields(RIGHT_MARKER, 32'd100, 32'd0, 32'd0, 32'd0, 8'd50, 23'd1000000);
		send_fields(RIGHT_MARKER, -32'sd200000, 32'd0, 32'd0, 32'd0, 8'd50, 23'd1000000);
		for (int i = 0; i < 16; i++) begin
			send_road_like(LEFT_MARKER, 32'sd100000);
		end
	endtask

	// Random traffic: mostly jump sequences, some full-range noise.
	task automatic test_random(input int count);
		boundary_kind_e kind;
		lbg_pkg::in_t noise;
		int sent;
		sent = 0;
		while (sent < count) begin
			if ($urandom_range(0, 9) == 0) begin
				noise = lbg_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom});
				send_boundary(noise);
				sent++;
			end else begin
				kind = boundary_kind_e'($urandom_range(0, 3));
				send_road_like(kind, $urandom_range(0, 13106) - 6553);
				if ($urandom_range(0, 1) == 0) begin
					send_road_like(kind, kind[0] ? -32'sd163841 - $urandom_range(0, 200000)
						: 32'sd163841 + $urandom_range(0, 200000));
				end else begin
					send_road_like(kind, $urandom_range(0, 524288) - 262144);
				end
				sent += 2;
				repeat ($urandom_range(0, 20)) begin
					send_road_like(kind, $urandom_range(0, 524288) - 262144);
					sent++;
				end
			end
		end
	endtask

	// Register settings, extremes included.
	task automatic test_vehicle_settings();
		write_register(lbg_pkg::CFG_WHEEL_BASE, 20'd0);
		write_register(lbg_pkg::CFG_HOST_WIDTH, 20'd0);
		test_random(150);
		write_register(lbg_pkg::CFG_WHEEL_BASE, 20'd655360);
		write_register(lbg_pkg::CFG_HOST_WIDTH, 20'd262144);
		long_hold_req = 1'b1;
		test_random(150);
		write_register(lbg_pkg::CFG_WHEEL_BASE, 20'hFFFFF);
		write_register(lbg_pkg::CFG_HOST_WIDTH, 20'hFFFFF);
		write_register(2'd2, 20'd12345);
		write_register(2'd3, 20'hAAAAA);
		test_random(100);
		write_register(lbg_pkg::CFG_WHEEL_BASE, 20'($urandom_range(0, 655360)));
		write_register(lbg_pkg::CFG_HOST_WIDTH, 20'($urandom_range(0, 262144)));
		test_random(150);
	endtask

	// Receiver: ready pattern picks a new random mode at regular intervals; one long hold-off.
	initial begin
		int mode;
		int hold_cnt;
		out_ready = 1'b0;
		mode = 0;
		hold_cnt = 0;
		forever begin
			@(negedge clk);
			if (cycle_count % 64 == 0) begin
				mode = $urandom_range(0, 2);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_cnt = 600;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready = 1'b0;
			end else if (mode == 0) begin
				out_ready = 1'b1;
			end else if (mode == 1) begin
				out_ready = $urandom_range(0, 1);
			end else begin
				out_ready = $urandom_range(0, 3) == 0;
			end
		end
	end

	// Compare every result transaction with the oldest expectation.
	always @(posedge clk) begin
		lbg_pkg::out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_geometry.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, out_data);
				error_count++;
			end else begin
				want = expected_geometry.pop_front();
				if (out_data.valid_res !== want.valid_res) begin
					$display("%0t: valid_res exp %h act %h", $realtime, want.valid_res,
						out_data.valid_res);
					error_count++;
				end
				if (out_data.distance !== want.distance) begin
					$display("%0t: distance exp %h act %h", $realtime, want.distance,
						out_data.distance);
					error_count++;
				end
				if (out_data.heading_deg !== want.heading_deg) begin
					$display("%0t: heading_deg exp %h act %h", $realtime, want.heading_deg,
						out_data.heading_deg);
					error_count++;
				end
				if (out_data.lateral_rate !== want.lateral_rate) begin
					$display("%0t: lateral_rate exp %h act %h", $realtime, want.lateral_rate,
						out_data.lateral_rate);
					error_count++;
				end
				if (out_data.curvature !== want.curvature) begin
					$display("%0t: curvature exp %h act %h", $realtime, want.curvature,
						out_data.curvature);
					error_count++;
				end
				if (out_data.curvature_rate !== want.curvature_rate) begin
					$display("%0t: curvature_rate exp %h act %h", $realtime,
						want.curvature_rate, out_data.curvature_rate);
					error_count++;
				end
				if (out_data.crossing_time !== want.crossing_time) begin
					$display("%0t: crossing_time exp %h act %h", $realtime,
						want.crossing_time, out_data.crossing_time);
					error_count++;
				end
				if (out_data.lane_change !== want.lane_change) begin
					$display("%0t: lane_change exp %h act %h", $realtime, want.lane_change,
						out_data.lane_change);
					error_count++;
				end
			end
		end
	end

	// Test sequence.
	initial begin
		error_count = 0;
		burst_left = 0;
		long_hold_req = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = lbg_pkg::CFG_WHEEL_BASE;
		cfg_data = '0;
		wheel_base_q = 20'd183501;
		host_width_q = 19'd124518;
		last_offset[0] = 32'sd117965;
		last_offset[1] = -32'sd117965;
		last_valid[0] = 1'b0;
		last_valid[1] = 1'b0;
		change_flag[0] = 1'b0;
		change_flag[1] = 1'b0;
		hold_count[0] = 0;
		hold_count[1] = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_lane_change();
		test_random(200);
		test_vehicle_settings();
		wait_idle();
		if (error_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
